// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define BZF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BZF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bzf_pkg.sv
// ----------------------------------------------------------------------------
// bzf_pkg
// Shared types, constants and fixed-point helpers of the Bezier flattener.
// ----------------------------------------------------------------------------
package bzf_pkg;

   localparam int QDEPTH = 2;
   localparam int ONE_Q16 = 65536;
   localparam logic [12:0] TENTH_Q16 = 13'd6554;

   typedef logic signed [15:0] in_coord_type;
   typedef logic signed [17:0] coord_type;
   typedef logic signed [37:0] prod_type;
   typedef logic [16:0]        tq_type;

   typedef struct packed {
      in_coord_type start_x;
      in_coord_type start_y;
      in_coord_type end_x;
      in_coord_type end_y;
   } req_item_type;

   // four control points of one curve
   typedef struct packed {
      coord_type p0x;
      coord_type p0y;
      coord_type p1x;
      coord_type p1y;
      coord_type p2x;
      coord_type p2y;
      coord_type p3x;
      coord_type p3y;
   } ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // (b - a) * t, t in Q16 with 0 <= t <= 1.0
   function automatic prod_type lerp_prod(coord_type a, coord_type b, tq_type t);
      logic signed [18:0] diff;
      logic signed [17:0] ts;
      logic signed [36:0] p;
      diff = $signed({b[17], b}) - $signed({a[17], a});
      ts   = $signed({1'b0, t});
      p    = diff * ts;
      return {p[36], p};
   endfunction

   // trunc((a * 2^16 + p) / 2^16), rounding toward zero
   function automatic coord_type lerp_fin(coord_type a, prod_type p);
      logic signed [37:0] num;
      logic signed [21:0] q;
      num = $signed({{4{a[17]}}, a, 16'b0}) + p;
      q   = num[37:16];
      if (num[37] && (num[15:0] != 16'b0)) begin
         q = q + 22'sd1;
      end
      return q[17:0];
   endfunction

endpackage

// File: rtl/bzf_ifs.sv
// ----------------------------------------------------------------------------
// bzf channel interfaces
// Valid/ready channels for endpoint requests and polyline vertex responses.
// ----------------------------------------------------------------------------
interface bzf_req_if
   import bzf_pkg::*;
();
   logic         valid;
   logic         ready;
   in_coord_type start_x;
   in_coord_type start_y;
   in_coord_type end_x;
   in_coord_type end_y;

   modport source (output valid, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

interface bzf_rsp_if
   import bzf_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last_point;

   modport source (output valid, output point_x, output point_y,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y,
                   input last_point, output ready);
endinterface

// File: rtl/cubic_bezier_flattener_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_top
// Cubic Bezier flattener: endpoints in, SEGMENTS+1 polyline vertices out.
// ----------------------------------------------------------------------------
// Each request transfer carries a start and an end point; the block derives
// two control points and returns SEGMENTS+1 vertices, the first being the
// start point and the last (flagged by last_point) the end point. Vertices
// leave at one per cycle; the back-end t sequencer issues one t value per
// cycle into a five-register de Casteljau pipeline. A two-entry queue
// between the control point front end and the back end lets the next
// request be taken while a curve is still being emitted. Output
// backpressure stalls the whole back-end pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_bezier_flattener_top
   import bzf_pkg::*;
#(
   parameter int SEGMENTS = 20
) (
   input  logic      clock,
   input  logic      reset,
   bzf_req_if.sink   req_ch,
   bzf_rsp_if.source rsp_ch
);

   queue_stat_type q_stat;
   logic           q_push;
   logic           q_pop;
   ctrl_type       q_wdata;
   ctrl_type       q_head;

   bzf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   bzf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   bzf_back #(
      .SEGMENTS (SEGMENTS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (q_head),
      .q_pop  (q_pop),
      .rsp_ch (rsp_ch)
   );

   `BZF_ASSERT(a_push_room, q_push |-> !q_stat.full, "push into full queue")
   `BZF_ASSERT(a_pop_data, q_pop |-> !q_stat.empty, "pop from empty queue")
   `BZF_ASSERT_NEXT(a_pop_frees, q_pop && !q_push, !q_stat.full, "queue full after pop")

endmodule

// File: rtl/bzf_front.sv
// ----------------------------------------------------------------------------
// bzf_front
// Takes endpoint transfers, classifies direction and derives control points.
// ----------------------------------------------------------------------------
module bzf_front
   import bzf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   bzf_req_if.sink        req_ch,
   input  queue_stat_type q_stat,
   output logic           q_push,
   output ctrl_type       q_data
);

   logic         hold_v_ff;
   logic         hold_v_in;
   req_item_type hold_ff;
   logic         take;

   logic signed [17:0] sx;
   logic signed [17:0] sy;
   logic signed [17:0] ex;
   logic signed [17:0] ey;
   logic               fwd;
   logic signed [17:0] dx_fwd;
   logic signed [17:0] dx_rev;
   logic [28:0]        tenth_prod;
   logic signed [17:0] d_fwd;
   logic [17:0]        off_sum;
   logic signed [17:0] off_rev;

   assign q_push       = hold_v_ff && !q_stat.full;
   assign req_ch.ready = !hold_v_ff || q_push;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_v_in = hold_v_ff;
      if (take) begin
         hold_v_in = 1'b1;
      end else if (q_push) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff.start_x <= req_ch.start_x;
         hold_ff.start_y <= req_ch.start_y;
         hold_ff.end_x   <= req_ch.end_x;
         hold_ff.end_y   <= req_ch.end_y;
      end
   end

   assign sx = $signed({{2{hold_ff.start_x[15]}}, hold_ff.start_x});
   assign sy = $signed({{2{hold_ff.start_y[15]}}, hold_ff.start_y});
   assign ex = $signed({{2{hold_ff.end_x[15]}}, hold_ff.end_x});
   assign ey = $signed({{2{hold_ff.end_y[15]}}, hold_ff.end_y});

   assign fwd    = (sx <= ex);
   assign dx_fwd = ex - sx;
   assign dx_rev = sx - ex;

   // forward: trunc(0.10 * dx) in Q16
   assign tenth_prod = dx_fwd[15:0] * TENTH_Q16;
   assign d_fwd      = $signed({5'b0, tenth_prod[28:16]});

   // reverse: trunc(1.5 * |dx|)
   assign off_sum = {2'b0, dx_rev[15:0]} + {1'b0, dx_rev[15:0], 1'b0};
   assign off_rev = $signed({1'b0, off_sum[17:1]});

   always_comb begin
      q_data.p0x = sx;
      q_data.p0y = sy;
      q_data.p1y = sy;
      q_data.p2y = ey;
      q_data.p3x = ex;
      q_data.p3y = ey;
      if (fwd) begin
         q_data.p1x = ex - d_fwd;
         q_data.p2x = sx + d_fwd;
      end else begin
         q_data.p1x = sx + off_rev;
         q_data.p2x = ex - off_rev;
      end
   end

endmodule

// File: rtl/bzf_queue.sv
// ----------------------------------------------------------------------------
// bzf_queue
// Short FIFO of control point sets between front and back.
// ----------------------------------------------------------------------------
module bzf_queue
   import bzf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ctrl_type       push_data,
   input  logic           pop,
   output ctrl_type       head,
   output queue_stat_type stat
);

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   ctrl_type        mem_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign stat.full  = (count_ff == CW'(QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/bzf_back.sv
// ----------------------------------------------------------------------------
// bzf_back
// Steps t over each curve and runs a stalling de Casteljau pipeline.
// ----------------------------------------------------------------------------
module bzf_back
   import bzf_pkg::*;
#(
   parameter int SEGMENTS = 20
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_stat_type q_stat,
   input  ctrl_type       head,
   output logic           q_pop,
   bzf_rsp_if.source      rsp_ch
);

   localparam int IW    = $clog2(SEGMENTS + 1);
   localparam int RW    = $clog2(SEGMENTS);
   localparam int TSTEP = ONE_Q16 / SEGMENTS;
   localparam int TREM  = ONE_Q16 % SEGMENTS;

   logic            adv;
   logic            issue;
   logic            at_end;

   logic [IW-1:0]   idx_ff;
   logic [IW-1:0]   idx_in;
   tq_type          t_ff;
   tq_type          t_in;
   logic [RW-1:0]   rem_ff;
   logic [RW-1:0]   rem_in;
   logic [RW:0]     rem_sum;
   logic            carry;

   coord_type       pin [4][2];

   logic            s1_v_ff;
   logic            s2_v_ff;
   logic            s3_v_ff;
   logic            s4_v_ff;
   logic            s1_last_ff;
   logic            s2_last_ff;
   logic            s3_last_ff;
   logic            s4_last_ff;
   tq_type          s1_t_ff;
   tq_type          s2_t_ff;
   tq_type          s3_t_ff;
   coord_type       s1_p_ff [4][2];
   coord_type       s2_b_ff [3][2];
   prod_type        s2_m_ff [3][2];
   coord_type       s3_b_ff [2][2];
   prod_type        s3_m_ff [2][2];
   coord_type       s4_b_ff [2];
   prod_type        s4_m_ff [2];
   coord_type       l1 [3][2];
   coord_type       l2 [2][2];

   logic            rsp_v_ff;
   coord_type       rsp_x_ff;
   coord_type       rsp_y_ff;
   logic            rsp_last_ff;

   assign adv    = !rsp_v_ff || rsp_ch.ready;
   assign issue  = adv && !q_stat.empty;
   assign at_end = (idx_ff == IW'(SEGMENTS));
   assign q_pop  = issue && at_end;

   // exact t = floor(i * 2^16 / SEGMENTS) by quotient and remainder steps
   assign rem_sum = {1'b0, rem_ff} + (RW + 1)'(TREM);
   assign carry   = (rem_sum >= (RW + 1)'(SEGMENTS));

   always_comb begin
      idx_in = idx_ff;
      t_in   = t_ff;
      rem_in = rem_ff;
      if (issue) begin
         if (at_end) begin
            idx_in = '0;
            t_in   = '0;
            rem_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            t_in   = t_ff + 17'(TSTEP) + {16'b0, carry};
            rem_in = carry ? RW'(rem_sum - (RW + 1)'(SEGMENTS)) : rem_sum[RW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         t_ff     <= '0;
         rem_ff   <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         t_ff   <= t_in;
         rem_ff <= rem_in;
         if (adv) begin
            s1_v_ff  <= issue;
            s2_v_ff  <= s1_v_ff;
            s3_v_ff  <= s2_v_ff;
            s4_v_ff  <= s3_v_ff;
            rsp_v_ff <= s4_v_ff;
         end
      end
   end

   assign pin[0][0] = head.p0x;
   assign pin[0][1] = head.p0y;
   assign pin[1][0] = head.p1x;
   assign pin[1][1] = head.p1y;
   assign pin[2][0] = head.p2x;
   assign pin[2][1] = head.p2y;
   assign pin[3][0] = head.p3x;
   assign pin[3][1] = head.p3y;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int d = 0; d < 2; d++) begin
            l1[j][d] = lerp_fin(s2_b_ff[j][d], s2_m_ff[j][d]);
         end
      end
      for (int j = 0; j < 2; j++) begin
         for (int d = 0; d < 2; d++) begin
            l2[j][d] = lerp_fin(s3_b_ff[j][d], s3_m_ff[j][d]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff    <= pin;
         s1_t_ff    <= t_ff;
         s1_last_ff <= at_end;
         s2_t_ff    <= s1_t_ff;
         s2_last_ff <= s1_last_ff;
         s3_t_ff    <= s2_t_ff;
         s3_last_ff <= s2_last_ff;
         s4_last_ff <= s3_last_ff;
         for (int d = 0; d < 2; d++) begin
            for (int j = 0; j < 3; j++) begin
               s2_b_ff[j][d] <= s1_p_ff[j][d];
               s2_m_ff[j][d] <= lerp_prod(s1_p_ff[j][d], s1_p_ff[j+1][d], s1_t_ff);
            end
            for (int j = 0; j < 2; j++) begin
               s3_b_ff[j][d] <= l1[j][d];
               s3_m_ff[j][d] <= lerp_prod(l1[j][d], l1[j+1][d], s2_t_ff);
            end
            s4_b_ff[d] <= l2[0][d];
            s4_m_ff[d] <= lerp_prod(l2[0][d], l2[1][d], s3_t_ff);
         end
         rsp_x_ff    <= lerp_fin(s4_b_ff[0], s4_m_ff[0]);
         rsp_y_ff    <= lerp_fin(s4_b_ff[1], s4_m_ff[1]);
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.point_x    = rsp_x_ff;
   assign rsp_ch.point_y    = rsp_y_ff;
   assign rsp_ch.last_point = rsp_last_ff;

endmodule

// File: tb/tb_cubic_bezier_flattener_top.sv
// ----------------------------------------------------------------------------
// tb_cubic_bezier_flattener_top
// Self-checking bench for the cubic Bezier flattener. Endpoint pairs go in on
// the request channel: a directed table first, then random curves. Each
// request transfer queues the SEGMENTS+1 vertices that a Q16 de Casteljau
// predictor gives. A few table rows instead carry a vertex typed in by hand.
// Every vertex transfer on the response channel is compared with the oldest
// queued vertex. The sender runs in bursts. The receiver stalls on a pattern
// that changes over time, with one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_flattener_top
   import bzf_pkg::*;
();

   localparam int SEGMENTS      = 20;
   localparam int TABLE_ROWS    = 16;
   localparam int RANDOM_CURVES = 285;
   localparam longint Q16_ONE   = 65536;
   localparam longint TENTH_Q16_VAL = 6554;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } vertex_type;

   // pinned: every vertex of the curve is (x, y)
   typedef struct {
      bit        pinned;
      coord_type x;
      coord_type y;
   } pin_tag_type;

   typedef struct {
      int sx;
      int sy;
      int ex;
      int ey;
      bit pinned;
      int px;
      int py;
   } curve_row_type;

   logic clock;
   logic reset;
   int   error_count = 0;

   vertex_type  expected_vertices[$];
   pin_tag_type pin_tags[$];

   bzf_req_if req_ch ();
   bzf_rsp_if rsp_ch ();

   cubic_bezier_flattener_top #(
      .SEGMENTS(SEGMENTS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   curve_row_type curve_rows [TABLE_ROWS] = '{
      '{0, 0, 0, 0, 1'b1, 0, 0},
      '{-32768, -32768, -32768, -32768, 1'b1, -32768, -32768},
      '{32767, 32767, 32767, 32767, 1'b1, 32767, 32767},
      '{12345, -321, 12345, -321, 1'b1, 12345, -321},
      '{-32768, -32768, 32767, 32767, 1'b0, 0, 0},
      '{32767, 32767, -32768, -32768, 1'b0, 0, 0},
      '{32767, -32768, -32768, 32767, 1'b0, 0, 0},
      '{-32768, 32767, 32767, -32768, 1'b0, 0, 0},
      '{100, -5000, 100, 5000, 1'b0, 0, 0},
      '{101, 0, 100, 0, 1'b0, 0, 0},
      '{-7, 3, 2, -3, 1'b0, 0, 0},
      '{20, -20, -1, 19, 1'b0, 0, 0},
      '{-1000, -1000, -3, -999, 1'b0, 0, 0},
      '{0, 0, 10, 10, 1'b0, 0, 0},
      '{-32768, 0, -32767, 0, 1'b0, 0, 0},
      '{5000, -32768, -5000, 32767, 1'b0, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   // trunc((a * 2^16 + (b - a) * t) / 2^16), toward zero
   function automatic longint interp_q16(longint a, longint b, longint t);
      return (a * Q16_ONE + (b - a) * t) / Q16_ONE;
   endfunction

   function automatic void predict_vertices(req_item_type r);
      longint sx, sy, ex, ey, c1x, c1y, c2x, c2y, d, off, t;
      longint ax, ay, bx, by, cx, cy, mx, my, nx, ny, vx, vy;
      vertex_type v;
      sx = r.start_x;
      sy = r.start_y;
      ex = r.end_x;
      ey = r.end_y;
      if (sx <= ex) begin
         d   = ((ex - sx) * TENTH_Q16_VAL) / Q16_ONE;
         c1x = ex - d;
         c2x = sx + d;
      end else begin
         d   = sx - ex;
         off = (3 * d) / 2;
         c1x = sx + off;
         c2x = ex - off;
      end
      c1y = sy;
      c2y = ey;
      for (int i = 0; i <= SEGMENTS; i++) begin
         if (i == 0) begin
            vx = sx;
            vy = sy;
         end else if (i == SEGMENTS) begin
            vx = ex;
            vy = ey;
         end else begin
            t  = (longint'(i) * Q16_ONE) / SEGMENTS;
            ax = interp_q16(sx, c1x, t);
            ay = interp_q16(sy, c1y, t);
            bx = interp_q16(c1x, c2x, t);
            by = interp_q16(c1y, c2y, t);
            cx = interp_q16(c2x, ex, t);
            cy = interp_q16(c2y, ey, t);
            mx = interp_q16(ax, bx, t);
            my = interp_q16(ay, by, t);
            nx = interp_q16(bx, cx, t);
            ny = interp_q16(by, cy, t);
            vx = interp_q16(mx, nx, t);
            vy = interp_q16(my, ny, t);
         end
         v.x    = vx[17:0];
         v.y    = vy[17:0];
         v.last = (i == SEGMENTS);
         expected_vertices = {expected_vertices, v};
      end
   endfunction

   function automatic in_coord_type corner_coord();
      case ($urandom_range(0, 3))
         0: return in_coord_type'(-32768);
         1: return in_coord_type'(32767);
         2: return in_coord_type'(0);
         default: return in_coord_type'(-1);
      endcase
   endfunction

   function automatic in_coord_type near_zero();
      return in_coord_type'(int'($urandom_range(0, 400)) - 200);
   endfunction

   function automatic req_item_type random_curve();
      req_item_type r;
      r.start_x = in_coord_type'($urandom);
      r.start_y = in_coord_type'($urandom);
      r.end_x   = in_coord_type'($urandom);
      r.end_y   = in_coord_type'($urandom);
      case ($urandom_range(0, 9))
         4, 5: begin
            r.start_x = near_zero();
            r.start_y = near_zero();
            r.end_x   = near_zero();
            r.end_y   = near_zero();
         end
         6: begin
            r.start_x = corner_coord();
            r.start_y = corner_coord();
            r.end_x   = corner_coord();
            r.end_y   = corner_coord();
         end
         7: r.end_x = r.start_x;
         8: begin
            r.end_x = r.start_x;
            r.end_y = r.start_y;
         end
         9: r.end_x = r.start_x + in_coord_type'(int'($urandom_range(0, 40)) - 20);
         default: ;
      endcase
      return r;
   endfunction

   task automatic offer_curve(input req_item_type item, input pin_tag_type tag);
      pin_tags = {pin_tags, tag};
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= item.start_x;
      req_ch.start_y <= item.start_y;
      req_ch.end_x   <= item.end_x;
      req_ch.end_y   <= item.end_y;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // request and response monitor in one block: push before pop on a shared edge
   always @(posedge clock) begin : monitor
      pin_tag_type tag;
      vertex_type  want;
      vertex_type  pin_vertex;
      req_item_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            tag.pinned = 1'b0;
            tag.x      = '0;
            tag.y      = '0;
            if (pin_tags.size() != 0) begin
               tag = pin_tags.pop_front();
            end
            if (tag.pinned) begin
               for (int i = 0; i <= SEGMENTS; i++) begin
                  pin_vertex.x    = tag.x;
                  pin_vertex.y    = tag.y;
                  pin_vertex.last = (i == SEGMENTS);
                  expected_vertices = {expected_vertices, pin_vertex};
               end
            end else begin
               seen.start_x = req_ch.start_x;
               seen.start_y = req_ch.start_y;
               seen.end_x   = req_ch.end_x;
               seen.end_y   = req_ch.end_y;
               predict_vertices(seen);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_vertices.size() == 0) begin
               error_count++;
               $display("%0t: vertex expected none actual x=%0d y=%0d last=%0b", $time,
                        rsp_ch.point_x, rsp_ch.point_y, rsp_ch.last_point);
            end else begin
               want = expected_vertices.pop_front();
               if (rsp_ch.point_x !== want.x) begin
                  error_count++;
                  $display("%0t: point_x expected %0d actual %0d", $time,
                           want.x, rsp_ch.point_x);
               end
               if (rsp_ch.point_y !== want.y) begin
                  error_count++;
                  $display("%0t: point_y expected %0d actual %0d", $time,
                           want.y, rsp_ch.point_y);
               end
               if (rsp_ch.last_point !== want.last) begin
                  error_count++;
                  $display("%0t: last_point expected %0b actual %0b", $time,
                           want.last, rsp_ch.last_point);
               end
            end
         end
      end
   end

   // receiver: ready pattern steps through four modes; one long hold-off to back up the block
   initial begin : receiver
      int cyc;
      cyc = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == 900) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            cyc += 400;
         end else begin
            case ((cyc / 200) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (cyc % 3 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      req_item_type item;
      pin_tag_type  tag;
      int burst_left;
      int gap;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.start_x <= '0;
      req_ch.start_y <= '0;
      req_ch.end_x   <= '0;
      req_ch.end_y   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;
      for (int n = 0; n < TABLE_ROWS + RANDOM_CURVES; n++) begin
         if (n < TABLE_ROWS) begin
            item.start_x = in_coord_type'(curve_rows[n].sx);
            item.start_y = in_coord_type'(curve_rows[n].sy);
            item.end_x   = in_coord_type'(curve_rows[n].ex);
            item.end_y   = in_coord_type'(curve_rows[n].ey);
            tag.pinned   = curve_rows[n].pinned;
            tag.x        = coord_type'(curve_rows[n].px);
            tag.y        = coord_type'(curve_rows[n].py);
         end else begin
            item       = random_curve();
            tag.pinned = 1'b0;
            tag.x      = '0;
            tag.y      = '0;
         end
         offer_curve(item, tag);
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ((n >= 120 && n < 180) || $urandom_range(0, 3) == 0) begin
               gap = 0;
            end else begin
               gap = $urandom_range(1, 30);
            end
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
